/* rtl/round_robin_quantum_scheduler_assert.svh */
// assertion helpers for the scheduler
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define RRQS_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// next-cycle implication
`define RRQS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

/* rtl/rrqs_pkg.sv */
`default_nettype none

package rrqs_pkg;

    localparam int MAX_TASKS = 16;
    localparam int ID_W      = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int SVC_W     = 8;
    localparam int TIME_W    = 16;
    localparam int QUANT_W   = 8;

    localparam logic [QUANT_W-1:0] QUANTUM_RESET = QUANT_W'(1);

    typedef logic [ID_W-1:0]    task_id_t;
    typedef logic [CNT_W-1:0]   ring_cnt_t;
    typedef logic [SVC_W-1:0]   svc_len_t;
    typedef logic [TIME_W-1:0]  tick_time_t;
    typedef logic [QUANT_W-1:0] quantum_t;

    typedef struct packed {
        logic     arrive_valid;
        task_id_t arrive_task;
        svc_len_t arrive_service;
    } tick_req_t;

    typedef struct packed {
        logic       busy_res;
        task_id_t   run_task;
        logic       first_run;
        tick_time_t response_time;
        logic       finished;
        tick_time_t turnaround_time;
    } result_t;

    // ready ring requests for one tick
    typedef struct packed {
        logic     push_a;
        task_id_t id_a;
        logic     push_b;
        task_id_t id_b;
        logic     pop;
    } ring_req_t;

    typedef struct packed {
        logic     pop_ok;
        task_id_t pop_id;
    } ring_rsp_t;

    typedef struct packed {
        logic       en;
        task_id_t   id;
        svc_len_t   service;
        tick_time_t stamp;
    } arrive_wr_t;

    typedef struct packed {
        logic     en;
        task_id_t id;
        svc_len_t remaining;
    } run_wr_t;

    typedef struct packed {
        svc_len_t   remaining;
        tick_time_t arrived;
        logic       started;
    } task_rec_t;

endpackage

`default_nettype wire

/* rtl/rrqs_stream_if.sv */
`default_nettype none

interface rrqs_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

/* rtl/rrqs_ring.sv */
`default_nettype none

module rrqs_ring (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire rrqs_pkg::ring_req_t req,
    output rrqs_pkg::ring_rsp_t     rsp
);

    rrqs_pkg::task_id_t  ring_mem [rrqs_pkg::MAX_TASKS];
    rrqs_pkg::task_id_t  head_reg;
    rrqs_pkg::task_id_t  tail_reg;
    rrqs_pkg::ring_cnt_t count_reg;

    logic                do_a;
    logic                do_b;
    logic                do_pop;
    rrqs_pkg::task_id_t  tail_a;
    rrqs_pkg::ring_cnt_t count_a;
    rrqs_pkg::ring_cnt_t count_b;

    localparam rrqs_pkg::ring_cnt_t DEPTH = rrqs_pkg::ring_cnt_t'(rrqs_pkg::MAX_TASKS);

    // a push into a full ring is dropped
    always_comb
    begin
        do_a    = req.push_a && (count_reg != DEPTH);
        tail_a  = tail_reg + rrqs_pkg::task_id_t'(do_a);
        count_a = count_reg + rrqs_pkg::ring_cnt_t'(do_a);
        do_b    = req.push_b && (count_a != DEPTH);
        count_b = count_a + rrqs_pkg::ring_cnt_t'(do_b);
        do_pop  = req.pop && (count_b != '0);
    end

    // an empty ring hands the first push of this tick straight through
    always_comb
    begin
        rsp.pop_ok = do_pop;
        if (count_reg != '0)
        begin
            rsp.pop_id = ring_mem[head_reg];
        end
        else if (do_a)
        begin
            rsp.pop_id = req.id_a;
        end
        else
        begin
            rsp.pop_id = req.id_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (step)
        begin
            head_reg  <= head_reg + rrqs_pkg::task_id_t'(do_pop);
            tail_reg  <= tail_a + rrqs_pkg::task_id_t'(do_b);
            count_reg <= count_b - rrqs_pkg::ring_cnt_t'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && do_a)
        begin
            ring_mem[tail_reg] <= req.id_a;
        end
        if (step && do_b)
        begin
            ring_mem[tail_a] <= req.id_b;
        end
    end

endmodule

`default_nettype wire

/* rtl/rrqs_task_table.sv */
`default_nettype none

module rrqs_task_table (
    input  wire logic                clk,
    input  wire logic                step,
    input  wire rrqs_pkg::arrive_wr_t arr_wr,
    input  wire rrqs_pkg::run_wr_t    run_wr,
    input  wire rrqs_pkg::task_id_t   rd_id,
    output rrqs_pkg::task_rec_t      rd_rec
);

    rrqs_pkg::svc_len_t   remaining_mem [rrqs_pkg::MAX_TASKS];
    rrqs_pkg::tick_time_t arrived_mem   [rrqs_pkg::MAX_TASKS];
    logic                 started_mem   [rrqs_pkg::MAX_TASKS];

    // a record written by this tick's arrival is seen at once
    always_comb
    begin
        if (arr_wr.en && (arr_wr.id == rd_id))
        begin
            rd_rec.remaining = arr_wr.service;
            rd_rec.arrived   = arr_wr.stamp;
            rd_rec.started   = 1'b0;
        end
        else
        begin
            rd_rec.remaining = remaining_mem[rd_id];
            rd_rec.arrived   = arrived_mem[rd_id];
            rd_rec.started   = started_mem[rd_id];
        end
    end

    // the run update wins over the arrival on the same entry
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < rrqs_pkg::MAX_TASKS; i++)
        begin
            if (step)
            begin
                if (arr_wr.en && (arr_wr.id == rrqs_pkg::task_id_t'(i)))
                begin
                    arrived_mem[i] <= arr_wr.stamp;
                end
                if (run_wr.en && (run_wr.id == rrqs_pkg::task_id_t'(i)))
                begin
                    remaining_mem[i] <= run_wr.remaining;
                    started_mem[i]   <= 1'b1;
                end
                else if (arr_wr.en && (arr_wr.id == rrqs_pkg::task_id_t'(i)))
                begin
                    remaining_mem[i] <= arr_wr.service;
                    started_mem[i]   <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/round_robin_quantum_scheduler.sv */
// Round-robin scheduler with a time quantum, one scheduling tick per arrive
// transfer. Each tick queues the arriving task, re-queues the task whose
// quantum ran out on the previous tick, takes the ring head when nothing
// runs and runs the holding task for one unit; it gives one result transfer.
// The arrive transfer lands in an input register, the whole tick is done in
// one pass of logic into the result register, and a new transfer is taken
// every cycle while the result side keeps up. While a result waits, the
// tick held in the input register stalls and arrive.ready stays low until
// the result is taken. The user must write the quantum through
// cfg_wr_en/cfg_wr_data only while no tick is in flight; the block itself
// does not enforce this.
`default_nettype none

`include "round_robin_quantum_scheduler_assert.svh"

module round_robin_quantum_scheduler (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire rrqs_pkg::quantum_t  cfg_wr_data,
    rrqs_stream_if.sink              arrive,
    rrqs_stream_if.source            result
);

    rrqs_pkg::quantum_t   quantum_reg;
    logic                 in_valid_reg;
    rrqs_pkg::tick_req_t  in_reg;
    logic                 out_valid_reg;
    rrqs_pkg::result_t    out_reg;

    logic                 running_valid_reg;
    logic                 running_valid_next;
    rrqs_pkg::task_id_t   running_task_reg;
    rrqs_pkg::task_id_t   running_task_next;
    rrqs_pkg::quantum_t   slice_count_reg;
    rrqs_pkg::quantum_t   slice_count_next;
    logic                 slice_expired_reg;
    logic                 slice_expired_next;
    rrqs_pkg::tick_time_t current_time_reg;

    logic                 step;
    rrqs_pkg::ring_req_t  ring_req;
    rrqs_pkg::ring_rsp_t  ring_rsp;
    rrqs_pkg::arrive_wr_t arr_wr;
    rrqs_pkg::run_wr_t    run_wr;
    rrqs_pkg::task_rec_t  rec;
    rrqs_pkg::task_id_t   cur_id;
    logic                 run_now;
    logic                 done;
    logic                 expire;
    logic [rrqs_pkg::QUANT_W:0] slice_inc;
    rrqs_pkg::result_t    res_next;

    assign step           = in_valid_reg && (!out_valid_reg || result.ready);
    assign arrive.ready   = !in_valid_reg || step;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= rrqs_pkg::QUANTUM_RESET;
        end
        else if (cfg_wr_en)
        begin
            quantum_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (arrive.ready)
        begin
            in_valid_reg <= arrive.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (arrive.ready && arrive.valid)
        begin
            in_reg <= arrive.payload;
        end
    end

    // expired task goes behind this tick's arrival
    always_comb
    begin
        ring_req.push_a = in_reg.arrive_valid;
        ring_req.id_a   = in_reg.arrive_task;
        ring_req.push_b = slice_expired_reg;
        ring_req.id_b   = running_task_reg;
        ring_req.pop    = !running_valid_reg;
    end

    rrqs_ring u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .req   (ring_req),
        .rsp   (ring_rsp)
    );

    // every 4-bit id fits the table, so no arrival is turned away
    always_comb
    begin
        arr_wr.en      = in_reg.arrive_valid;
        arr_wr.id      = in_reg.arrive_task;
        arr_wr.service = in_reg.arrive_service;
        arr_wr.stamp   = current_time_reg;
    end

    assign run_now = running_valid_reg || ring_rsp.pop_ok;
    assign cur_id  = running_valid_reg ? running_task_reg : ring_rsp.pop_id;

    rrqs_task_table u_table (
        .clk    (clk),
        .step   (step),
        .arr_wr (arr_wr),
        .run_wr (run_wr),
        .rd_id  (cur_id),
        .rd_rec (rec)
    );

    always_comb
    begin
        done      = (rec.remaining <= rrqs_pkg::svc_len_t'(1));
        // a fresh dispatch starts its slice from zero; zero quantum acts as one
        slice_inc = {1'b0, (running_valid_reg ? slice_count_reg : rrqs_pkg::quantum_t'(0))}
                    + (rrqs_pkg::QUANT_W + 1)'(1);
        expire    = !done && (slice_inc >= {1'b0, quantum_reg});

        run_wr.en        = run_now;
        run_wr.id        = cur_id;
        run_wr.remaining = done ? '0 : rec.remaining - rrqs_pkg::svc_len_t'(1);

        running_valid_next = run_now && !done && !expire;
        running_task_next  = run_now ? cur_id : running_task_reg;
        slice_count_next   = running_valid_next ? slice_inc[rrqs_pkg::QUANT_W-1:0] : '0;
        slice_expired_next = run_now && expire;

        res_next.busy_res        = run_now;
        res_next.run_task        = run_now ? cur_id : '0;
        res_next.first_run       = run_now && !rec.started;
        res_next.response_time   = res_next.first_run ? (current_time_reg - rec.arrived) : '0;
        res_next.finished        = run_now && done;
        res_next.turnaround_time = res_next.finished
                                   ? (current_time_reg + rrqs_pkg::tick_time_t'(1) - rec.arrived)
                                   : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_valid_reg <= 1'b0;
            running_task_reg  <= '0;
            slice_count_reg   <= '0;
            slice_expired_reg <= 1'b0;
            current_time_reg  <= '0;
        end
        else if (step)
        begin
            running_valid_reg <= running_valid_next;
            running_task_reg  <= running_task_next;
            slice_count_reg   <= slice_count_next;
            slice_expired_reg <= slice_expired_next;
            current_time_reg  <= current_time_reg + rrqs_pkg::tick_time_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= res_next;
        end
    end

    `RRQS_ASSERT_IMPLY(a_expired_not_running, clk, rst_n, slice_expired_reg,
                       !running_valid_reg)
    `RRQS_ASSERT_NEXT(a_finish_releases, clk, rst_n, step && res_next.finished,
                      !running_valid_reg && !slice_expired_reg)
    `RRQS_ASSERT_IMPLY(a_idle_result_clear, clk, rst_n, out_valid_reg && !out_reg.busy_res,
                       out_reg.run_task == '0 && !out_reg.first_run && !out_reg.finished)

endmodule

`default_nettype wire
